### design/spct_pkg.sv
package spct_pkg;

   // Number of register stages from the request port to the response port
   localparam int PIPE_DEPTH = 8;

   // Query opcodes
   localparam logic OP_SPHERE_SPHERE = 1'b0;
   localparam logic OP_SPHERE_PLANE  = 1'b1;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PLANE_CORNER_ZERO = 2'd0,
      CSR_PLANE_CORNER_ONE  = 2'd1,
      CSR_PLANE_CORNER_TWO  = 2'd2
   } csr_index_type;

endpackage

### design/spct_channels.sv
// Query channel: one collision query per transaction
interface spct_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic signed [COORD_WIDTH-1:0] first_x;
   logic signed [COORD_WIDTH-1:0] first_y;
   logic signed [COORD_WIDTH-1:0] first_z;
   logic        [COORD_WIDTH-2:0] first_radius;
   logic signed [COORD_WIDTH-1:0] second_x;
   logic signed [COORD_WIDTH-1:0] second_y;
   logic signed [COORD_WIDTH-1:0] second_z;
   logic        [COORD_WIDTH-2:0] second_radius;

   modport source (
      output valid, opcode, first_x, first_y, first_z, first_radius,
             second_x, second_y, second_z, second_radius,
      input  ready
   );
   modport sink (
      input  valid, opcode, first_x, first_y, first_z, first_radius,
             second_x, second_y, second_z, second_radius,
      output ready
   );
endinterface

// Result channel: one flag per transaction
interface spct_rsp_if;
   logic valid;
   logic ready;
   logic collided;

   modport source (output valid, collided, input ready);
   modport sink (input valid, collided, output ready);
endinterface

// Register write channel
interface spct_csr_if #(parameter int COORD_WIDTH = 16);
   logic                                   valid;
   logic                                   ready;
   logic [spct_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [3*COORD_WIDTH-1:0]               data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/sphere_plane_collision_test.sv
// Sphere collision test. Each query either tests two spheres against each
// other (opcode 0: hit when squared center distance < (ra+rb)^2) or tests
// the first sphere against the plane through three corner registers
// (opcode 1: with n = (c1-c0) x (c2-c1) and s = n.(p-c0), hit when
// s^2 < r^2 * n.n; a zero normal reports a hit whenever r > 0). All math
// is exact integer math. The block is an 8-stage pipeline: it accepts one
// query per clock until back-pressure from the result port fills it. The
// depth is set by the chain of multiplies on the plane path (edge cross
// products, then dot products, then the wide squares, which are split
// into half-width partial products over two stages). A stage stalls only
// when it is full and the next stage, or the result port after the last,
// cannot take its data, so bubbles are squeezed out under back-pressure.
// Results come out in query order. Corner registers may only be written
// while no query is in flight; a register write is accepted every cycle.
module sphere_plane_collision_test #(
   parameter int COORD_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   spct_req_if.sink  req_chan,
   spct_rsp_if.source rsp_chan,
   spct_csr_if.sink  csr_chan
);

   localparam int W     = COORD_WIDTH;
   localparam int DEPTH = spct_pkg::PIPE_DEPTH;
   localparam int DW    = W + 1;           // coordinate differences
   localparam int PW    = 2 * W + 2;       // product of two differences
   localparam int RW    = W;               // sum of radii
   localparam int RSQW  = 2 * W;           // squared radius sum
   localparam int R1W   = W - 1;           // one radius
   localparam int R1SQW = 2 * W - 2;       // one radius squared
   localparam int D2W   = 2 * W + 4;       // squared center distance
   localparam int NCW   = 2 * W + 3;       // normal component
   localparam int NQW   = NCW + DW;        // normal times offset
   localparam int NSQW  = 2 * NCW;         // normal component squared
   localparam int SW    = NQW + 2;         // plane distance numerator
   localparam int NW    = NSQW + 2;        // squared normal length
   localparam int SLW   = (SW + 1) / 2;    // low half of |s|
   localparam int SHW   = SW - SLW;        // high half of |s|
   localparam int NLW   = NW / 2;          // low half of n.n
   localparam int NHW   = NW - NLW;        // high half of n.n
   localparam int S2W   = 2 * SW;          // s squared
   localparam int RNW   = NW + R1SQW;      // r^2 * n.n
   localparam int HHW   = 2 * SHW;         // high by high partial product
   localparam int LLW   = 2 * SLW;         // low by low partial product
   localparam int NHRW  = NHW + R1SQW;     // high n.n half times r^2
   localparam int NLRW  = NLW + R1SQW;     // low n.n half times r^2

   // ---------------------------------------------------------------
   // Corner registers
   // ---------------------------------------------------------------
   logic [3*W-1:0] corner0_ff, corner1_ff, corner2_ff;
   logic [3*W-1:0] corner0_in, corner1_in, corner2_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      corner0_in = corner0_ff;
      corner1_in = corner1_ff;
      corner2_in = corner2_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            spct_pkg::CSR_PLANE_CORNER_ZERO: corner0_in = csr_chan.data;
            spct_pkg::CSR_PLANE_CORNER_ONE:  corner1_in = csr_chan.data;
            spct_pkg::CSR_PLANE_CORNER_TWO:  corner2_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner0_ff <= '0;
         corner1_ff <= '0;
         corner2_ff <= '0;
      end else begin
         corner0_ff <= corner0_in;
         corner1_ff <= corner1_in;
         corner2_ff <= corner2_in;
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or moves on
   // ---------------------------------------------------------------
   logic [DEPTH:1] vld_ff, vld_in, adv;

   always_comb begin
      adv[DEPTH] = !vld_ff[DEPTH] || rsp_chan.ready;
      for (int i = DEPTH - 1; i >= 1; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[1] = adv[1] ? req_chan.valid : vld_ff[1];
      for (int i = 2; i <= DEPTH; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = adv[1];

   // ---------------------------------------------------------------
   // Stage 1: differences and radius sum
   // ---------------------------------------------------------------
   logic signed [W-1:0] pa [3];
   logic signed [W-1:0] pb [3];
   logic signed [W-1:0] c0 [3];
   logic signed [W-1:0] c1 [3];
   logic signed [W-1:0] c2 [3];

   logic                 s1_op_in, s1_op_ff;
   logic signed [DW-1:0] s1_d_in [3];
   logic signed [DW-1:0] s1_d_ff [3];
   logic signed [DW-1:0] s1_e_in [3];
   logic signed [DW-1:0] s1_e_ff [3];
   logic signed [DW-1:0] s1_f_in [3];
   logic signed [DW-1:0] s1_f_ff [3];
   logic signed [DW-1:0] s1_q_in [3];
   logic signed [DW-1:0] s1_q_ff [3];
   logic [RW-1:0]        s1_rs_in, s1_rs_ff;
   logic [R1W-1:0]       s1_r1_in, s1_r1_ff;

   always_comb begin
      pa[0] = req_chan.first_x;
      pa[1] = req_chan.first_y;
      pa[2] = req_chan.first_z;
      pb[0] = req_chan.second_x;
      pb[1] = req_chan.second_y;
      pb[2] = req_chan.second_z;
      for (int k = 0; k < 3; k++) begin
         c0[k] = $signed(corner0_ff[k*W +: W]);
         c1[k] = $signed(corner1_ff[k*W +: W]);
         c2[k] = $signed(corner2_ff[k*W +: W]);
         s1_d_in[k] = DW'(pb[k]) - DW'(pa[k]);
         s1_e_in[k] = DW'(c1[k]) - DW'(c0[k]);
         s1_f_in[k] = DW'(c2[k]) - DW'(c1[k]);
         s1_q_in[k] = DW'(pa[k]) - DW'(c0[k]);
      end
      s1_op_in = req_chan.opcode;
      s1_rs_in = RW'(req_chan.first_radius) + RW'(req_chan.second_radius);
      s1_r1_in = req_chan.first_radius;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_op_ff <= s1_op_in;
         s1_d_ff  <= s1_d_in;
         s1_e_ff  <= s1_e_in;
         s1_f_ff  <= s1_f_in;
         s1_q_ff  <= s1_q_in;
         s1_rs_ff <= s1_rs_in;
         s1_r1_ff <= s1_r1_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: squares of distances, edge cross terms, radius squares
   // ---------------------------------------------------------------
   logic                 s2_op_in, s2_op_ff;
   logic signed [PW-1:0] s2_dsq_in [3];
   logic signed [PW-1:0] s2_dsq_ff [3];
   logic signed [PW-1:0] s2_ef_in [6];
   logic signed [PW-1:0] s2_ef_ff [6];
   logic signed [DW-1:0] s2_q_ff [3];
   logic [RSQW-1:0]      s2_rsq_in, s2_rsq_ff;
   logic [R1SQW-1:0]     s2_r1sq_in, s2_r1sq_ff;
   logic                 s2_r1nz_in, s2_r1nz_ff;

   always_comb begin
      s2_op_in = s1_op_ff;
      for (int k = 0; k < 3; k++) begin
         s2_dsq_in[k] = PW'(s1_d_ff[k]) * PW'(s1_d_ff[k]);
      end
      // cross product terms of e x f
      s2_ef_in[0] = PW'(s1_e_ff[1]) * PW'(s1_f_ff[2]);
      s2_ef_in[1] = PW'(s1_e_ff[2]) * PW'(s1_f_ff[1]);
      s2_ef_in[2] = PW'(s1_e_ff[2]) * PW'(s1_f_ff[0]);
      s2_ef_in[3] = PW'(s1_e_ff[0]) * PW'(s1_f_ff[2]);
      s2_ef_in[4] = PW'(s1_e_ff[0]) * PW'(s1_f_ff[1]);
      s2_ef_in[5] = PW'(s1_e_ff[1]) * PW'(s1_f_ff[0]);
      s2_rsq_in   = RSQW'(s1_rs_ff) * RSQW'(s1_rs_ff);
      s2_r1sq_in  = R1SQW'(s1_r1_ff) * R1SQW'(s1_r1_ff);
      s2_r1nz_in  = |s1_r1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_op_ff   <= s2_op_in;
         s2_dsq_ff  <= s2_dsq_in;
         s2_ef_ff   <= s2_ef_in;
         s2_q_ff    <= s1_q_ff;
         s2_rsq_ff  <= s2_rsq_in;
         s2_r1sq_ff <= s2_r1sq_in;
         s2_r1nz_ff <= s2_r1nz_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: sphere-sphere decision, plane normal
   // ---------------------------------------------------------------
   logic                  s3_op_ff;
   logic                  s3_hitss_in, s3_hitss_ff;
   logic signed [NCW-1:0] s3_n_in [3];
   logic signed [NCW-1:0] s3_n_ff [3];
   logic signed [DW-1:0]  s3_q_ff [3];
   logic [R1SQW-1:0]      s3_r1sq_ff;
   logic                  s3_r1nz_ff;

   always_comb begin
      logic [D2W-1:0] d2;
      d2 = '0;
      for (int k = 0; k < 3; k++) begin
         d2 = d2 + D2W'($unsigned(s2_dsq_ff[k]));
      end
      s3_hitss_in = d2 < D2W'(s2_rsq_ff);
      s3_n_in[0]  = NCW'(s2_ef_ff[0]) - NCW'(s2_ef_ff[1]);
      s3_n_in[1]  = NCW'(s2_ef_ff[2]) - NCW'(s2_ef_ff[3]);
      s3_n_in[2]  = NCW'(s2_ef_ff[4]) - NCW'(s2_ef_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_op_ff    <= s2_op_ff;
         s3_hitss_ff <= s3_hitss_in;
         s3_n_ff     <= s3_n_in;
         s3_q_ff     <= s2_q_ff;
         s3_r1sq_ff  <= s2_r1sq_ff;
         s3_r1nz_ff  <= s2_r1nz_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: dot product terms n.q and n.n
   // ---------------------------------------------------------------
   logic                   s4_op_ff;
   logic                   s4_hitss_ff;
   logic signed [NQW-1:0]  s4_nq_in [3];
   logic signed [NQW-1:0]  s4_nq_ff [3];
   logic signed [NSQW-1:0] s4_nsq_in [3];
   logic signed [NSQW-1:0] s4_nsq_ff [3];
   logic [R1SQW-1:0]       s4_r1sq_ff;
   logic                   s4_r1nz_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s4_nq_in[k]  = NQW'(s3_n_ff[k]) * NQW'(s3_q_ff[k]);
         s4_nsq_in[k] = NSQW'(s3_n_ff[k]) * NSQW'(s3_n_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_op_ff    <= s3_op_ff;
         s4_hitss_ff <= s3_hitss_ff;
         s4_nq_ff    <= s4_nq_in;
         s4_nsq_ff   <= s4_nsq_in;
         s4_r1sq_ff  <= s3_r1sq_ff;
         s4_r1nz_ff  <= s3_r1nz_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: sum the dot products, take |s|
   // ---------------------------------------------------------------
   logic             s5_op_ff;
   logic             s5_hitss_ff;
   logic [SW-1:0]    s5_sabs_in, s5_sabs_ff;
   logic [NW-1:0]    s5_nn_in, s5_nn_ff;
   logic [R1SQW-1:0] s5_r1sq_ff;
   logic             s5_r1nz_ff;

   always_comb begin
      logic signed [SW-1:0] s;
      s = SW'(s4_nq_ff[0]) + SW'(s4_nq_ff[1]) + SW'(s4_nq_ff[2]);
      s5_sabs_in = s[SW-1] ? $unsigned(-s) : $unsigned(s);
      s5_nn_in = NW'($unsigned(s4_nsq_ff[0])) + NW'($unsigned(s4_nsq_ff[1]))
               + NW'($unsigned(s4_nsq_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_op_ff    <= s4_op_ff;
         s5_hitss_ff <= s4_hitss_ff;
         s5_sabs_ff  <= s5_sabs_in;
         s5_nn_ff    <= s5_nn_in;
         s5_r1sq_ff  <= s4_r1sq_ff;
         s5_r1nz_ff  <= s4_r1nz_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: half-width partial products of s^2 and r^2 * n.n
   // ---------------------------------------------------------------
   logic                   s6_op_ff;
   logic                   s6_hitss_ff;
   logic [2*SHW-1:0]       s6_hh_in, s6_hh_ff;
   logic [SW-1:0]          s6_hl_in, s6_hl_ff;
   logic [2*SLW-1:0]       s6_ll_in, s6_ll_ff;
   logic [NHW+R1SQW-1:0]   s6_nhr_in, s6_nhr_ff;
   logic [NLW+R1SQW-1:0]   s6_nlr_in, s6_nlr_ff;
   logic                   s6_nz_in, s6_nz_ff;
   logic                   s6_r1nz_ff;

   always_comb begin
      logic [SHW-1:0] s_hi;
      logic [SLW-1:0] s_lo;
      logic [NHW-1:0] n_hi;
      logic [NLW-1:0] n_lo;
      s_hi = s5_sabs_ff[SW-1:SLW];
      s_lo = s5_sabs_ff[SLW-1:0];
      n_hi = s5_nn_ff[NW-1:NLW];
      n_lo = s5_nn_ff[NLW-1:0];
      s6_hh_in  = HHW'(s_hi) * HHW'(s_hi);
      s6_hl_in  = SW'(s_hi) * SW'(s_lo);
      s6_ll_in  = LLW'(s_lo) * LLW'(s_lo);
      s6_nhr_in = NHRW'(n_hi) * NHRW'(s5_r1sq_ff);
      s6_nlr_in = NLRW'(n_lo) * NLRW'(s5_r1sq_ff);
      s6_nz_in  = s5_nn_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_op_ff    <= s5_op_ff;
         s6_hitss_ff <= s5_hitss_ff;
         s6_hh_ff    <= s6_hh_in;
         s6_hl_ff    <= s6_hl_in;
         s6_ll_ff    <= s6_ll_in;
         s6_nhr_ff   <= s6_nhr_in;
         s6_nlr_ff   <= s6_nlr_in;
         s6_nz_ff    <= s6_nz_in;
         s6_r1nz_ff  <= s5_r1nz_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 7: assemble the two wide products
   // ---------------------------------------------------------------
   logic           s7_op_ff;
   logic           s7_hitss_ff;
   logic [S2W-1:0] s7_s2_in, s7_s2_ff;
   logic [RNW-1:0] s7_rn_in, s7_rn_ff;
   logic           s7_nz_ff;
   logic           s7_r1nz_ff;

   always_comb begin
      s7_s2_in = (S2W'(s6_hh_ff) << (2 * SLW)) + (S2W'(s6_hl_ff) << (SLW + 1))
               + S2W'(s6_ll_ff);
      s7_rn_in = (RNW'(s6_nhr_ff) << NLW) + RNW'(s6_nlr_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_op_ff    <= s6_op_ff;
         s7_hitss_ff <= s6_hitss_ff;
         s7_s2_ff    <= s7_s2_in;
         s7_rn_ff    <= s7_rn_in;
         s7_nz_ff    <= s6_nz_ff;
         s7_r1nz_ff  <= s6_r1nz_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 8: final decision, output register
   // ---------------------------------------------------------------
   logic s8_hit_in, s8_hit_ff;

   always_comb begin
      if (s7_op_ff == spct_pkg::OP_SPHERE_PLANE) begin
         // zero normal: the plane is at distance 0 from every point
         s8_hit_in = s7_nz_ff ? s7_r1nz_ff : (s7_s2_ff < S2W'(s7_rn_ff));
      end else begin
         s8_hit_in = s7_hitss_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s8_hit_ff <= s8_hit_in;
      end
   end

   assign rsp_chan.valid    = vld_ff[DEPTH];
   assign rsp_chan.collided = s8_hit_ff;

endmodule

### design/spct_checker.sv
module spct_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic collided
);

   localparam int CW = $clog2(spct_pkg::PIPE_DEPTH + 1);

   // Transactions accepted but not yet delivered
   logic [CW-1:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + CW'(1);
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pending_in = pending_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(collided))
      else $error("stalled result changed or dropped");

   // No result without an outstanding query
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result without a pending query");

   // Never more in flight than the pipeline holds
   a_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CW'(spct_pkg::PIPE_DEPTH))
      else $error("too many queries in flight");

   // Queries are refused only when a result is held up
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("query refused without back-pressure");

endmodule

bind sphere_plane_collision_test spct_checker u_spct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .collided  (rsp_chan.collided)
);
